// ----- hdl/cre_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cre_pkg
// Shared constants and controller/datapath interface types for the clock
// replacement entry cache.
// ----------------------------------------------------------------------------
package cre_pkg;

  localparam int ENTRIES_DEF    = 3;
  localparam int DATA_WIDTH_DEF = 64;
  localparam int KEY_WIDTH_DEF  = 16;

  typedef struct packed {
    logic load_in;
    logic scan_step;
    logic set_ref;
    logic write_hit;
    logic insert_fill;
    logic clear_adv;
    logic replace;
    logic res_miss;
    logic res_hit_upd;
    logic res_hit_word;
    logic emit;
  } cre_cmd_t;

  typedef struct packed {
    logic probe_hit;
    logic scan_end;
    logic is_update;
    logic full;
    logic ref_at_hand;
    logic out_busy;
  } cre_status_t;

endpackage
`default_nettype wire

// ----- hdl/cre_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/cre_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cre_datapath
// Key and word stores, reference bits, clock hand, serial key search and
// result registers of the clock replacement entry cache.
// ----------------------------------------------------------------------------
module cre_datapath #(
  parameter int ENTRIES    = cre_pkg::ENTRIES_DEF,
  parameter int DATA_WIDTH = cre_pkg::DATA_WIDTH_DEF,
  parameter int KEY_WIDTH  = cre_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cre_pkg::cre_cmd_t       cmd,
  output cre_pkg::cre_status_t         st,
  input  wire logic                    kind,
  input  wire logic [KEY_WIDTH-1:0]    key,
  input  wire logic [DATA_WIDTH-1:0]   entry_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         hit,
  output logic      [DATA_WIDTH-1:0]   read_data
);

  import cre_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  logic                  kind_q;
  logic [KEY_WIDTH-1:0]  key_q;
  logic [DATA_WIDTH-1:0] data_q;

  logic [CW-1:0]         fill_count;
  logic [AW-1:0]         hand;
  logic [ENTRIES-1:0]    ref_bits;
  logic [CW-1:0]         idx;
  logic                  probe_pend;
  logic [AW-1:0]         probe_slot;
  logic                  res_hit;
  logic [DATA_WIDTH-1:0] res_data;

  logic                  scan_more;
  logic                  key_we;
  logic [AW-1:0]         key_waddr;
  logic [KEY_WIDTH-1:0]  key_rdata;
  logic                  word_we;
  logic [AW-1:0]         word_waddr;
  logic [DATA_WIDTH-1:0] word_rdata;

  assign scan_more = (idx < fill_count);

  assign key_we    = cmd.insert_fill || cmd.replace;
  assign key_waddr = cmd.insert_fill ? fill_count[AW-1:0] : hand;

  assign word_we    = cmd.insert_fill || cmd.replace || cmd.write_hit;
  assign word_waddr = cmd.write_hit ? probe_slot : key_waddr;

  cre_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_q),
    .raddr (idx[AW-1:0]),
    .rdata (key_rdata)
  );

  cre_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (ENTRIES)
  ) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_waddr),
    .wdata (data_q),
    .raddr (probe_slot),
    .rdata (word_rdata)
  );

  always_comb begin
    st.probe_hit   = probe_pend && (key_rdata == key_q);
    st.scan_end    = !scan_more && !probe_pend;
    st.is_update   = kind_q;
    st.full        = (fill_count == CW'(ENTRIES));
    st.ref_at_hand = ref_bits[hand];
    st.out_busy    = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_q <= kind;
      key_q  <= key;
      data_q <= entry_data;
    end
    if (cmd.scan_step && scan_more) begin
      probe_slot <= idx[AW-1:0];
    end
    if (cmd.res_miss) begin
      res_hit  <= 1'b0;
      res_data <= '0;
    end else if (cmd.res_hit_upd) begin
      res_hit  <= 1'b1;
      res_data <= '0;
    end else if (cmd.res_hit_word) begin
      res_hit  <= 1'b1;
      res_data <= word_rdata;
    end
    if (cmd.emit) begin
      hit       <= res_hit;
      read_data <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      hand       <= '0;
      ref_bits   <= '0;
      idx        <= '0;
      probe_pend <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // advance the serial key search
      if (cmd.load_in) begin
        idx <= '0;
      end else if (cmd.scan_step && scan_more) begin
        idx <= idx + CW'(1);
      end
      probe_pend <= cmd.scan_step && scan_more;

      if (cmd.insert_fill) begin
        fill_count <= fill_count + CW'(1);
      end

      if (cmd.set_ref) begin
        ref_bits[probe_slot] <= 1'b1;
      end else if (cmd.clear_adv) begin
        ref_bits[hand] <= 1'b0;
      end

      if (cmd.clear_adv) begin
        hand <= (hand == AW'(ENTRIES - 1)) ? '0 : hand + AW'(1);
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(ENTRIES))
    else $error("fill count beyond capacity");

  a_hand_bound: assert property (@(posedge clk) disable iff (rst)
    hand < AW'(ENTRIES - 1) || hand == AW'(ENTRIES - 1))
    else $error("clock hand beyond last slot");

  a_probe_filled: assert property (@(posedge clk) disable iff (rst)
    probe_pend |-> (CW'(probe_slot) < fill_count))
    else $error("probe of an empty slot");

  a_insert_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.insert_fill |-> !st.full)
    else $error("fill insert while full");

  a_replace_full: assert property (@(posedge clk) disable iff (rst)
    cmd.replace |-> (st.full && !ref_bits[hand]))
    else $error("replacement of a referenced slot or before full");
`endif

endmodule
`default_nettype wire

// ----- hdl/cre_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cre_ctrl
// Sequencer of the clock replacement entry cache: input beat, key search,
// word read, clock sweep and result hand-off.
// ----------------------------------------------------------------------------
module cre_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire cre_pkg::cre_status_t  st,
  output cre_pkg::cre_cmd_t          cmd
);

  import cre_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_WORD  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.probe_hit) begin
          cmd.set_ref = 1'b1;
          if (st.is_update) begin
            cmd.write_hit   = 1'b1;
            cmd.res_hit_upd = 1'b1;
            state_next      = S_OUT;
          end else begin
            state_next = S_WORD;
          end
        end else if (st.scan_end) begin
          if (!st.is_update) begin
            cmd.res_miss = 1'b1;
            state_next   = S_OUT;
          end else if (!st.full) begin
            cmd.insert_fill = 1'b1;
            cmd.res_miss    = 1'b1;
            state_next      = S_OUT;
          end else begin
            state_next = S_SWEEP;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_WORD: begin
        cmd.res_hit_word = 1'b1;
        state_next       = S_OUT;
      end
      S_SWEEP: begin
        if (!st.ref_at_hand) begin
          cmd.replace  = 1'b1;
          cmd.res_miss = 1'b1;
          state_next   = S_OUT;
        end else begin
          cmd.clear_adv = 1'b1;
        end
      end
      S_OUT: begin
        if (!st.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.res_miss, cmd.res_hit_upd, cmd.res_hit_word}) <= 1)
    else $error("conflicting result loads");

  a_sweep_from_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && $past(state) != S_SWEEP) |-> $past(st.full && st.is_update))
    else $error("sweep entered without a full-cache update miss");

  a_emit_then_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (state == S_IDLE))
    else $error("result emitted without return to idle");
`endif

endmodule
`default_nettype wire

// ----- hdl/clock_replacement_entry_cache.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clock_replacement_entry_cache
// Fully associative keyed cache with clock (second-chance) replacement.
// ----------------------------------------------------------------------------
// One item is in work at a time. From its input beat to its result beat an
// item passes the key search, which reads the key RAM one slot per cycle over
// the filled slots; a lookup hit then reads the word RAM, and an update miss
// on a full cache walks the clock hand one slot per cycle until it finds a
// clear reference bit. A result waits in the output register while the next
// input beat is taken. Lookups return zero data on a miss; updates always
// return zero data and report whether the key was already held.
// ----------------------------------------------------------------------------
module clock_replacement_entry_cache #(
  parameter int ENTRIES    = cre_pkg::ENTRIES_DEF,
  parameter int DATA_WIDTH = cre_pkg::DATA_WIDTH_DEF,
  parameter int KEY_WIDTH  = cre_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  kind,
  input  wire logic [KEY_WIDTH-1:0]  key,
  input  wire logic [DATA_WIDTH-1:0] entry_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       hit,
  output logic      [DATA_WIDTH-1:0] read_data
);

  import cre_pkg::*;

  cre_cmd_t    cmd;
  cre_status_t st;

  cre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  cre_datapath #(
    .ENTRIES    (ENTRIES),
    .DATA_WIDTH (DATA_WIDTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .kind       (kind),
    .key        (key),
    .entry_data (entry_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .read_data  (read_data)
  );

endmodule
`default_nettype wire
